@@ sv/tfc_pkg.sv @@
// tfc_pkg: constants, codes and shared types of the flag cache.
// No dependencies; used by the interfaces and all modules.
`default_nettype none

package tfc_pkg;

  localparam int ENTRIES   = 128;
  localparam int KEY_BITS  = 64;
  localparam int TICK_BITS = 32;
  localparam int IDX_W     = $clog2(ENTRIES);

  // Port field widths (fixed)
  localparam int KEY_W   = 64;
  localparam int NOW_W   = 32;
  localparam int RAW_W   = 32;
  localparam int SLOT_W  = 7;
  localparam int LIFE_W  = 32;

  localparam logic [LIFE_W-1:0] LIFETIME_RESET = LIFE_W'(2000);

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_FILL   = 1'b1;

  // Controller to datapath
  typedef struct packed {
    logic load;    // capture request, restart scan
    logic rd_en;   // read entry at scan address, advance
    logic commit;  // write fill entry, load response register
  } tfc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic addr_last;  // scan address is the last entry
    logic out_free;   // response register can take a new result
  } tfc_stat_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]  key;
    logic                 value;
    logic [TICK_BITS-1:0] stamp;
  } tfc_entry_t;

endpackage

`default_nettype wire

@@ sv/tfc_if.sv @@
// tfc_if: valid/ready channels of the flag cache (request, response, config).
// Depends on tfc_pkg for field widths.
`default_nettype none

interface tfc_req_if;
  logic                             valid;
  logic                             ready;
  logic                             operation;
  logic [tfc_pkg::KEY_W-1:0]        flag_id;
  logic [tfc_pkg::NOW_W-1:0]        now_tick;
  logic                             fill_found;
  logic signed [tfc_pkg::RAW_W-1:0] fill_raw_value;

  modport source (output valid, operation, flag_id, now_tick, fill_found,
                  fill_raw_value, input ready);
  modport sink   (input valid, operation, flag_id, now_tick, fill_found,
                  fill_raw_value, output ready);
endinterface

interface tfc_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       hit;
  logic                       flag_value;
  logic [tfc_pkg::SLOT_W-1:0] slot_index;

  modport source (output valid, hit, flag_value, slot_index, input ready);
  modport sink   (input valid, hit, flag_value, slot_index, output ready);
endinterface

interface tfc_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [tfc_pkg::LIFE_W-1:0] lifetime_ticks;

  modport source (output valid, lifetime_ticks, input ready);
  modport sink   (input valid, lifetime_ticks, output ready);
endinterface

`default_nettype wire

@@ sv/tfc_ctrl.sv @@
// tfc_ctrl: sequencer for the flag cache; one scan over all entries per request.
// Depends on tfc_pkg (command and status types).
`default_nettype none

module tfc_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_ready,
  input  wire tfc_pkg::tfc_stat_t stat,
  output tfc_pkg::tfc_cmd_t       cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_LAST = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.rd_en = 1'b1;
        if (stat.addr_last) begin
          state_next = S_LAST;
        end
      end
      // last entry is compared here
      S_LAST: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

@@ sv/tfc_dpath.sv @@
// tfc_dpath: entry store, valid bits, scan compare, lifetime register and
// response register of the flag cache. Depends on tfc_pkg.
`default_nettype none

module tfc_dpath (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire tfc_pkg::tfc_cmd_t                  cmd,
  output tfc_pkg::tfc_stat_t                      stat,
  // request payload
  input  wire logic                               in_operation,
  input  wire logic [tfc_pkg::KEY_W-1:0]          in_flag_id,
  input  wire logic [tfc_pkg::NOW_W-1:0]          in_now_tick,
  input  wire logic                               in_fill_found,
  input  wire logic signed [tfc_pkg::RAW_W-1:0]   in_fill_raw_value,
  // config write
  input  wire logic                               cfg_we,
  input  wire logic [tfc_pkg::LIFE_W-1:0]         cfg_data,
  // response
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic                                    out_hit,
  output logic                                    out_flag_value,
  output logic [tfc_pkg::SLOT_W-1:0]              out_slot_index
);

  tfc_pkg::tfc_entry_t mem [tfc_pkg::ENTRIES];
  logic [tfc_pkg::ENTRIES-1:0] entry_valid;

  logic [tfc_pkg::LIFE_W-1:0] lifetime;

  // captured request
  logic                          op_q;
  logic [tfc_pkg::KEY_BITS-1:0]  key_q;
  logic [tfc_pkg::TICK_BITS-1:0] now_q;
  logic                          val_q;

  // scan pipeline
  logic [tfc_pkg::IDX_W-1:0] addr;
  logic                      rd_pend;
  logic [tfc_pkg::IDX_W-1:0] rd_idx;
  logic                      rd_vld;
  tfc_pkg::tfc_entry_t       rd_ent;

  // trackers
  logic                      found;
  logic [tfc_pkg::IDX_W-1:0] found_idx;
  logic                      found_val;
  logic                      free_found;
  logic [tfc_pkg::IDX_W-1:0] free_idx;

  logic [tfc_pkg::TICK_BITS-1:0] age;
  logic                          key_eq;
  logic                          fresh;
  logic                          take;
  logic [tfc_pkg::IDX_W-1:0]     slot;
  logic                          mem_we;

  assign age    = now_q - rd_ent.stamp;
  assign key_eq = rd_vld && (rd_ent.key == key_q);
  assign fresh  = age < tfc_pkg::TICK_BITS'(lifetime);
  // fill matches regardless of age
  assign take   = rd_pend && !found && key_eq && ((op_q == tfc_pkg::OP_FILL) || fresh);

  always_comb begin
    if (found) begin
      slot = found_idx;
    end else if (free_found) begin
      slot = free_idx;
    end else begin
      slot = now_q[tfc_pkg::IDX_W-1:0];  // now mod ENTRIES
    end
  end

  assign mem_we = cmd.commit && (op_q == tfc_pkg::OP_FILL);

  assign stat.addr_last = (addr == tfc_pkg::IDX_W'(tfc_pkg::ENTRIES - 1));
  assign stat.out_free  = !out_valid || out_ready;

  // entry store: one read, one write port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[slot] <= '{key: key_q, value: val_q, stamp: now_q};
    end
    rd_ent <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (mem_we) begin
      entry_valid[slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lifetime <= tfc_pkg::LIFETIME_RESET;
    end else if (cfg_we) begin
      lifetime <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= in_operation;
      key_q <= in_flag_id[tfc_pkg::KEY_BITS-1:0];
      now_q <= in_now_tick[tfc_pkg::TICK_BITS-1:0];
      val_q <= in_fill_found && (in_fill_raw_value != '0);
    end
    rd_idx <= addr;
    rd_vld <= entry_valid[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      addr       <= '0;
      rd_pend    <= 1'b0;
      found      <= 1'b0;
      found_idx  <= '0;
      found_val  <= 1'b0;
      free_found <= 1'b0;
      free_idx   <= '0;
    end else begin
      rd_pend <= cmd.rd_en;
      if (cmd.load) begin
        addr       <= '0;
        found      <= 1'b0;
        free_found <= 1'b0;
      end else begin
        if (cmd.rd_en) begin
          addr <= addr + 1'b1;
        end
        if (take) begin
          found     <= 1'b1;
          found_idx <= rd_idx;
          found_val <= rd_ent.value;
        end
        if (rd_pend && !free_found && !rd_vld) begin
          free_found <= 1'b1;
          free_idx   <= rd_idx;
        end
      end
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (op_q == tfc_pkg::OP_FILL) begin
        out_hit        <= 1'b1;
        out_flag_value <= val_q;
        out_slot_index <= tfc_pkg::SLOT_W'(slot);
      end else begin
        out_hit        <= found;
        out_flag_value <= found && found_val;
        out_slot_index <= found ? tfc_pkg::SLOT_W'(found_idx) : '0;
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/ttl_flag_cache_top.sv @@
// ttl_flag_cache_top: fully associative flag cache with expiry.
// Depends on tfc_pkg, tfc_if.sv (channels), tfc_ctrl and tfc_dpath.
//
// Usage:
//   req  - lookup (operation 0) or fill (operation 1) requests, valid/ready.
//   rsp  - one result per request: hit, flag_value, slot_index.
//   cfg  - write of lifetime_ticks; always ready, write only while idle.
// Sequence:
//   A request is taken in the idle state, then all 128 entries are read
//   one per cycle from the entry store (single read port), followed by
//   the compare of the last entry and the commit to the response register.
//   No new request is taken until that commit, so the entry scan length
//   sets the sustained request rate.
// Stall:
//   The result sits in an output register. If it has not been taken when
//   the next scan ends, the sequencer waits before committing; no result
//   is dropped and the fill write waits with it.
// Reset:
//   rst clears all valid bits at once (no clearing pass) and sets
//   lifetime_ticks to 2000. Key, value and stamp storage is not reset.
`default_nettype none

module ttl_flag_cache_top (
  input  wire logic clk,
  input  wire logic rst,
  tfc_req_if.sink   req,
  tfc_rsp_if.source rsp,
  tfc_cfg_if.sink   cfg
);

  tfc_pkg::tfc_cmd_t  cmd;
  tfc_pkg::tfc_stat_t stat;
  logic               req_ready;

  assign req.ready = req_ready;
  assign cfg.ready = 1'b1;

  // Sequencer: idle -> scan -> last compare -> commit
  tfc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Store, compare and response register
  tfc_dpath u_dpath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .stat              (stat),
    .in_operation      (req.operation),
    .in_flag_id        (req.flag_id),
    .in_now_tick       (req.now_tick),
    .in_fill_found     (req.fill_found),
    .in_fill_raw_value (req.fill_raw_value),
    .cfg_we            (cfg.valid),
    .cfg_data          (cfg.lifetime_ticks),
    .out_valid         (rsp.valid),
    .out_ready         (rsp.ready),
    .out_hit           (rsp.hit),
    .out_flag_value    (rsp.flag_value),
    .out_slot_index    (rsp.slot_index)
  );

endmodule

`default_nettype wire
